FILE: hdl/bmc_pkg.sv
package bmc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_X_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_LAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_LAST  = 3'd5;

  localparam int VOXEL_W = 8;
  localparam int COUNT_W = 37;
  localparam int SUM_W   = 48;
  localparam int CENT_W  = 20;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [SUM_W-1:0]   sum_z;
  } vol_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hdl/bmc_front.sv
module bmc_front #(
  parameter int COORD_BITS = bmc_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_push,
  input  logic [bmc_pkg::VOXEL_W-1:0]    in_voxel_value,
  input  logic                           q_full,
  output logic                           q_push,
  output bmc_pkg::vol_t                  q_data
);

  logic [COORD_BITS-1:0] reg_r   [bmc_pkg::NUM_REGS];
  logic [COORD_BITS-1:0] reg_nxt [bmc_pkg::NUM_REGS];

  logic [COORD_BITS-1:0]         col_r, col_nxt, row_r, row_nxt, slc_r, slc_nxt;
  logic [bmc_pkg::COUNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [bmc_pkg::SUM_W-1:0]     sx_r, sx_nxt, sx_inc;
  logic [bmc_pkg::SUM_W-1:0]     sy_r, sy_nxt, sy_inc;
  logic [bmc_pkg::SUM_W-1:0]     sz_r, sz_nxt, sz_inc;

  logic acc, hit, end_x, end_y, end_z, cfg_hit;

  assign acc     = in_push && !q_full;
  assign hit     = in_voxel_value != '0;
  assign cfg_hit = cfg_we && (cfg_index < bmc_pkg::CFG_IDX_W'(bmc_pkg::NUM_REGS));

  assign cnt_inc = hit ? cnt_r + bmc_pkg::COUNT_W'(1) : cnt_r;
  assign sx_inc  = hit ? sx_r + bmc_pkg::SUM_W'(col_r) : sx_r;
  assign sy_inc  = hit ? sy_r + bmc_pkg::SUM_W'(row_r) : sy_r;
  assign sz_inc  = hit ? sz_r + bmc_pkg::SUM_W'(slc_r) : sz_r;

  assign end_x = col_r >= reg_r[bmc_pkg::REG_X_LAST];
  assign end_y = row_r >= reg_r[bmc_pkg::REG_Y_LAST];
  assign end_z = slc_r >= reg_r[bmc_pkg::REG_Z_LAST];

  assign q_data = '{count: cnt_inc, sum_x: sx_inc, sum_y: sy_inc, sum_z: sz_inc};

  always_comb begin
    reg_nxt = reg_r;
    col_nxt = col_r;
    row_nxt = row_r;
    slc_nxt = slc_r;
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sz_nxt  = sz_r;
    q_push  = 1'b0;
    if (cfg_hit) begin
      reg_nxt[cfg_index] = COORD_BITS'(cfg_data);
      col_nxt = reg_nxt[bmc_pkg::REG_X_FIRST];
      row_nxt = reg_nxt[bmc_pkg::REG_Y_FIRST];
      slc_nxt = reg_nxt[bmc_pkg::REG_Z_FIRST];
      cnt_nxt = '0;
      sx_nxt  = '0;
      sy_nxt  = '0;
      sz_nxt  = '0;
    end else if (acc) begin
      if (end_x && end_y && end_z) begin
        q_push  = 1'b1;
        col_nxt = reg_r[bmc_pkg::REG_X_FIRST];
        row_nxt = reg_r[bmc_pkg::REG_Y_FIRST];
        slc_nxt = reg_r[bmc_pkg::REG_Z_FIRST];
        cnt_nxt = '0;
        sx_nxt  = '0;
        sy_nxt  = '0;
        sz_nxt  = '0;
      end else begin
        cnt_nxt = cnt_inc;
        sx_nxt  = sx_inc;
        sy_nxt  = sy_inc;
        sz_nxt  = sz_inc;
        if (!end_x) begin
          col_nxt = col_r + COORD_BITS'(1);
        end else begin
          col_nxt = reg_r[bmc_pkg::REG_X_FIRST];
          if (!end_y) begin
            row_nxt = row_r + COORD_BITS'(1);
          end else begin
            row_nxt = reg_r[bmc_pkg::REG_Y_FIRST];
            slc_nxt = slc_r + COORD_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r <= '{default: '0};
      col_r <= '0;
      row_r <= '0;
      slc_r <= '0;
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sz_r  <= '0;
    end else begin
      reg_r <= reg_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      slc_r <= slc_nxt;
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sz_r  <= sz_nxt;
    end
  end

endmodule

FILE: hdl/bmc_queue.sv
module bmc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bmc_pkg::vol_t      din,
  input  logic               pop,
  output bmc_pkg::vol_t      dout,
  output bmc_pkg::q_status_t stat
);

  bmc_pkg::vol_t                mem_r [bmc_pkg::QDEPTH];
  logic [bmc_pkg::QPTR_W-1:0]   wr_r, rd_r;
  logic [bmc_pkg::QCNT_W-1:0]   cnt_r;
  logic                         do_push, do_pop;

  assign stat.full  = cnt_r == bmc_pkg::QCNT_W'(bmc_pkg::QDEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + bmc_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + bmc_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + bmc_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - bmc_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/bmc_back.sv
module bmc_back #(
  parameter int FRAC_BITS = bmc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  bmc_pkg::vol_t                q_data,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic                         out_any_found,
  output logic [bmc_pkg::COUNT_W-1:0]  out_voxel_count,
  output logic [bmc_pkg::CENT_W-1:0]   out_centroid_x,
  output logic [bmc_pkg::CENT_W-1:0]   out_centroid_y,
  output logic [bmc_pkg::CENT_W-1:0]   out_centroid_z
);

  localparam int DIV_W  = bmc_pkg::SUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DIV_W);
  localparam int CW     = bmc_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CW-1:0]     div_r, div_nxt;
  logic [DIV_W-1:0]  dvd_r [3];
  logic [DIV_W-1:0]  dvd_nxt [3];
  logic [DIV_W-1:0]  quo_r [3];
  logic [DIV_W-1:0]  quo_nxt [3];
  logic [CW-1:0]     rem_r [3];
  logic [CW-1:0]     rem_nxt [3];
  logic [CW:0]       trial [3];
  logic              ge [3];
  logic [bmc_pkg::SUM_W-1:0] sum_in [3];
  logic [bmc_pkg::CENT_W-1:0] cent [3];

  assign sum_in[0] = q_data.sum_x;
  assign sum_in[1] = q_data.sum_y;
  assign sum_in[2] = q_data.sum_z;

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_r[i], dvd_r[i][DIV_W-1]};
      ge[i]    = trial[i] >= {1'b0, div_r};
      cent[i]  = (|quo_r[i][DIV_W-1:bmc_pkg::CENT_W]) ? '1 : quo_r[i][bmc_pkg::CENT_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    div_nxt   = div_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          div_nxt  = q_data.count;
          step_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            dvd_nxt[i] = DIV_W'(sum_in[i]) << FRAC_BITS;
            quo_nxt[i] = '0;
            rem_nxt[i] = '0;
          end
          state_nxt = (q_data.count == '0) ? S_HOLD : S_RUN;
        end
      end
      S_RUN: begin
        for (int i = 0; i < 3; i++) begin
          dvd_nxt[i] = dvd_r[i] << 1;
          quo_nxt[i] = {quo_r[i][DIV_W-2:0], ge[i]};
          rem_nxt[i] = ge[i] ? CW'(trial[i] - {1'b0, div_r}) : trial[i][CW-1:0];
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_W - 1)) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_pop) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    div_r  <= div_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_empty       = state_r != S_HOLD;
  assign out_voxel_count = div_r;
  assign out_any_found   = div_r != '0;
  assign out_centroid_x  = cent[0];
  assign out_centroid_y  = cent[1];
  assign out_centroid_z  = cent[2];

endmodule

FILE: hdl/binary_mask_centroid_unit.sv
// channel   direction  handshake          payload
// in_       input      in_push / in_full  in_voxel_value
// out_      output     out_pop / out_empty out_any_found, out_voxel_count, out_centroid_x/y/z
// cfg_      input      cfg_we             cfg_index, cfg_data
//
// One voxel transfer per cycle while in_full is low; coordinates and sums update in the
// front accumulator. The last voxel of a volume queues its totals (two volumes deep);
// the back divider loads them and forms SUM_W + FRAC_BITS quotient bits (56 at defaults),
// three axes side by side, or skips the division when the count is zero, then holds the
// result until out_pop and returns to S_IDLE to load the next volume. in_full rises only
// while the queue is full. Synchronous reset clears extent registers, positions, sums,
// queue and result state; a write to an extent register restarts the volume in progress.
module binary_mask_centroid_unit #(
  parameter int COORD_BITS = bmc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bmc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [bmc_pkg::VOXEL_W-1:0]    in_voxel_value,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_any_found,
  output logic [bmc_pkg::COUNT_W-1:0]    out_voxel_count,
  output logic [bmc_pkg::CENT_W-1:0]     out_centroid_x,
  output logic [bmc_pkg::CENT_W-1:0]     out_centroid_y,
  output logic [bmc_pkg::CENT_W-1:0]     out_centroid_z
);

  bmc_pkg::vol_t      push_data, pop_data;
  bmc_pkg::q_status_t q_stat;
  logic               q_push, q_pop;

  assign in_full = q_stat.full;

  bmc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_voxel_value (in_voxel_value),
    .q_full         (q_stat.full),
    .q_push         (q_push),
    .q_data         (push_data)
  );

  bmc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_data),
    .pop   (q_pop),
    .dout  (pop_data),
    .stat  (q_stat)
  );

  bmc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_stat.empty),
    .q_data          (pop_data),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_any_found   (out_any_found),
    .out_voxel_count (out_voxel_count),
    .out_centroid_x  (out_centroid_x),
    .out_centroid_y  (out_centroid_y),
    .out_centroid_z  (out_centroid_z)
  );

endmodule

FILE: hdl/bmc_checker.sv
module bmc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic                          out_any_found,
  input logic [bmc_pkg::COUNT_W-1:0]   out_voxel_count,
  input logic [bmc_pkg::CENT_W-1:0]    out_centroid_x,
  input logic [bmc_pkg::CENT_W-1:0]    out_centroid_y,
  input logic [bmc_pkg::CENT_W-1:0]    out_centroid_z
);

  a_reset_empty: assert property (@(posedge clk) (rst_n && !$past(rst_n)) |-> out_empty)
    else $error("result shown right after reset");

  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_any_found == (out_voxel_count != '0)))
    else $error("any_found disagrees with voxel_count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_any_found) |->
      (out_centroid_x == '0 && out_centroid_y == '0 && out_centroid_z == '0))
    else $error("nonzero centroid for empty volume");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_voxel_count) && $stable(out_centroid_x)))
    else $error("stalled result changed");

endmodule

bind binary_mask_centroid_unit bmc_checker u_bmc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_any_found   (out_any_found),
  .out_voxel_count (out_voxel_count),
  .out_centroid_x  (out_centroid_x),
  .out_centroid_y  (out_centroid_y),
  .out_centroid_z  (out_centroid_z)
);

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bmc_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [bmc_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam int VOXEL_BUDGET = 1700;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic                        any_found;
    logic [bmc_pkg::COUNT_W-1:0] count;
    logic [bmc_pkg::CENT_W-1:0]  cx;
    logic [bmc_pkg::CENT_W-1:0]  cy;
    logic [bmc_pkg::CENT_W-1:0]  cz;
  } centroid_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_push = 1'b0;
  logic                           in_full;
  logic [bmc_pkg::VOXEL_W-1:0]    in_voxel_value = '0;
  logic                           out_empty;
  logic                           out_pop = 1'b0;
  logic                           out_any_found;
  logic [bmc_pkg::COUNT_W-1:0]    out_voxel_count;
  logic [bmc_pkg::CENT_W-1:0]     out_centroid_x;
  logic [bmc_pkg::CENT_W-1:0]     out_centroid_y;
  logic [bmc_pkg::CENT_W-1:0]     out_centroid_z;

  // predictor state
  logic [bmc_pkg::CFG_DATA_W-1:0]     ext_reg [bmc_pkg::NUM_REGS];
  logic [bmc_pkg::COORD_BITS_DEF-1:0] scan_x, scan_y, scan_z;
  logic [bmc_pkg::COUNT_W-1:0]        hit_total;
  logic [bmc_pkg::SUM_W-1:0]          sum_x, sum_y, sum_z;

  centroid_t centroid_q[$];
  int        mismatches = 0;
  int        voxels_sent = 0;
  logic      steady = 1'b0;

  binary_mask_centroid_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_voxel_value  (in_voxel_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_any_found   (out_any_found),
    .out_voxel_count (out_voxel_count),
    .out_centroid_x  (out_centroid_x),
    .out_centroid_y  (out_centroid_y),
    .out_centroid_z  (out_centroid_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void restart_scan();
    scan_x = ext_reg[bmc_pkg::REG_X_FIRST];
    scan_y = ext_reg[bmc_pkg::REG_Y_FIRST];
    scan_z = ext_reg[bmc_pkg::REG_Z_FIRST];
    hit_total = '0;
    sum_x = '0;
    sum_y = '0;
    sum_z = '0;
  endfunction

  function automatic logic [bmc_pkg::CENT_W-1:0] fixed_mean(
      logic [bmc_pkg::SUM_W-1:0] sum, logic [bmc_pkg::COUNT_W-1:0] cnt);
    logic [63:0] q;
    if (cnt == 0) return '0;
    q = ({16'd0, sum} << bmc_pkg::FRAC_BITS_DEF) / {27'd0, cnt};
    return (q > 64'hF_FFFF) ? '1 : q[bmc_pkg::CENT_W-1:0];
  endfunction

  function automatic void take_voxel(logic [bmc_pkg::VOXEL_W-1:0] v);
    centroid_t r;
    logic ex, ey, ez;
    if (v != 0) begin
      hit_total = hit_total + 1'b1;
      sum_x = sum_x + scan_x;
      sum_y = sum_y + scan_y;
      sum_z = sum_z + scan_z;
    end
    ex = scan_x >= ext_reg[bmc_pkg::REG_X_LAST];
    ey = scan_y >= ext_reg[bmc_pkg::REG_Y_LAST];
    ez = scan_z >= ext_reg[bmc_pkg::REG_Z_LAST];
    if (ex && ey && ez) begin
      r.any_found = hit_total != 0;
      r.count = hit_total;
      r.cx = fixed_mean(sum_x, hit_total);
      r.cy = fixed_mean(sum_y, hit_total);
      r.cz = fixed_mean(sum_z, hit_total);
      centroid_q.push_back(r);
      restart_scan();
    end else if (!ex) begin
      scan_x = scan_x + 1'b1;
    end else begin
      scan_x = ext_reg[bmc_pkg::REG_X_FIRST];
      if (!ey) begin
        scan_y = scan_y + 1'b1;
      end else begin
        scan_y = ext_reg[bmc_pkg::REG_Y_FIRST];
        scan_z = scan_z + 1'b1;
      end
    end
  endfunction

  function automatic int axis_span(logic [bmc_pkg::CFG_DATA_W-1:0] first,
                                   logic [bmc_pkg::CFG_DATA_W-1:0] last);
    return (last > first) ? int'(last) - int'(first) + 1 : 1;
  endfunction

  function automatic int scan_len();
    return axis_span(ext_reg[bmc_pkg::REG_X_FIRST], ext_reg[bmc_pkg::REG_X_LAST]) *
           axis_span(ext_reg[bmc_pkg::REG_Y_FIRST], ext_reg[bmc_pkg::REG_Y_LAST]) *
           axis_span(ext_reg[bmc_pkg::REG_Z_FIRST], ext_reg[bmc_pkg::REG_Z_LAST]);
  endfunction

  function automatic logic [bmc_pkg::VOXEL_W-1:0] pick_voxel(int density);
    return ($urandom_range(99) < density) ?
           bmc_pkg::VOXEL_W'($urandom_range(1, 255)) : '0;
  endfunction

  function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s: expected %0h actual %0h", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin
    centroid_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (centroid_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual count %0h", $time,
                 out_voxel_count);
      end else begin
        want = centroid_q.pop_front();
        check_field("any_found", want.any_found, out_any_found);
        check_field("voxel_count", want.count, out_voxel_count);
        check_field("centroid_x", want.cx, out_centroid_x);
        check_field("centroid_y", want.cy, out_centroid_y);
        check_field("centroid_z", want.cz, out_centroid_z);
      end
    end
    out_pop <= steady || ($urandom_range(99) >= 18);
  end

  task automatic send_voxel(input logic [bmc_pkg::VOXEL_W-1:0] v);
    while (!steady && $urandom_range(99) < 18) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_voxel_value <= v;
    do @(posedge clk); while (in_full);
    take_voxel(v);
    voxels_sent++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (centroid_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bmc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bmc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx < bmc_pkg::NUM_REGS) begin
      ext_reg[idx] = val;
      restart_scan();
    end
  endtask

  task automatic configure(input logic [bmc_pkg::CFG_DATA_W-1:0] x0, x1, y0, y1, z0, z1);
    wait_idle();
    write_reg(bmc_pkg::REG_X_FIRST, x0);
    write_reg(bmc_pkg::REG_X_LAST, x1);
    write_reg(bmc_pkg::REG_Y_FIRST, y0);
    write_reg(bmc_pkg::REG_Y_LAST, y1);
    write_reg(bmc_pkg::REG_Z_FIRST, z0);
    write_reg(bmc_pkg::REG_Z_LAST, z1);
  endtask

  task automatic pick_axis(input int max_span,
                           output logic [bmc_pkg::CFG_DATA_W-1:0] first,
                           output logic [bmc_pkg::CFG_DATA_W-1:0] last);
    int span;
    span = ($urandom_range(7) == 0) ? $urandom_range(1, max_span) : $urandom_range(1, 3);
    case ($urandom_range(9))
      0: begin
        first = bmc_pkg::CFG_DATA_W'($urandom_range(1, 4095));
        last = bmc_pkg::CFG_DATA_W'($urandom_range(0, int'(first) - 1));
      end
      1: begin
        first = '0;
        last = bmc_pkg::CFG_DATA_W'(span - 1);
      end
      2: begin
        first = bmc_pkg::CFG_DATA_W'(4096 - span);
        last = '1;
      end
      default: begin
        first = bmc_pkg::CFG_DATA_W'($urandom_range(0, 4096 - span));
        last = bmc_pkg::CFG_DATA_W'(int'(first) + span - 1);
      end
    endcase
  endtask

  // after reset every extent is a single voxel
  task automatic test_unit_extent();
    send_voxel(8'h00);
    send_voxel(8'hFF);
    send_voxel(8'h01);
    send_voxel(8'h80);
  endtask

  task automatic test_extreme_extents();
    configure(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_voxel(8'hFF);
    send_voxel(8'h00);
    configure(12'hFFE, 12'hFFF, 12'h000, 12'h001, 12'hFFF, 12'hFFF);
    send_voxel(8'hFF);
    send_voxel(8'h01);
    send_voxel(8'h02);
    send_voxel(8'h04);
  endtask

  task automatic test_inverted_extent();
    configure(12'hFFF, 12'h000, 12'h003, 12'h001, 12'h007, 12'h002);
    send_voxel(8'h80);
    send_voxel(8'h00);
  endtask

  task automatic test_empty_volume();
    configure(12'h000, 12'h001, 12'h000, 12'h000, 12'h000, 12'h000);
    send_voxel(8'h00);
    send_voxel(8'h00);
  endtask

  // spare indexes leave the volume alone, a real write restarts it
  task automatic test_spare_index_and_abort();
    configure(12'd10, 12'd11, 12'd20, 12'd21, 12'd30, 12'd30);
    send_voxel(8'h11);
    send_voxel(8'h22);
    wait_idle();
    write_reg(IDX_SPARE_HI, 12'hFFF);
    write_reg(IDX_SPARE_LO, 12'hAAA);
    send_voxel(8'h00);
    send_voxel(8'h40);
    send_voxel(8'h55);
    send_voxel(8'h66);
    wait_idle();
    write_reg(bmc_pkg::REG_X_FIRST, 12'd10);
    send_voxel(8'h01);
    send_voxel(8'h00);
    send_voxel(8'h00);
    send_voxel(8'h08);
  endtask

  task automatic test_random_volumes();
    logic [bmc_pkg::CFG_DATA_W-1:0] x0, x1, y0, y1, z0, z1;
    int vols, len, density, cut;
    logic dirty;
    vols = 0;
    dirty = 1'b1;
    while (voxels_sent < VOXEL_BUDGET) begin
      if (dirty || $urandom_range(2) == 0) begin
        wait_idle();
        if ($urandom_range(7) == 0)
          write_reg($urandom_range(1) ? IDX_SPARE_LO : IDX_SPARE_HI,
                    bmc_pkg::CFG_DATA_W'($urandom()));
        pick_axis(16, x0, x1);
        pick_axis(4, y0, y1);
        pick_axis(4, z0, z1);
        configure(x0, x1, y0, y1, z0, z1);
        dirty = 1'b0;
      end
      steady = (vols >= 20 && vols < 40);
      len = scan_len();
      case ($urandom_range(3))
        0: density = 0;
        1: density = 100;
        default: density = $urandom_range(5, 95);
      endcase
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(0, len - 1);
        repeat (cut) send_voxel(pick_voxel(density));
        dirty = 1'b1;
      end else begin
        repeat (len) send_voxel(pick_voxel(density));
      end
      if (vols == 50) drain();
      vols++;
    end
    steady = 1'b0;
  endtask

  initial begin
    int n;
    for (n = 0; n < bmc_pkg::NUM_REGS; n++) ext_reg[n] = '0;
    restart_scan();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unit_extent();
    test_extreme_extents();
    test_inverted_extent();
    test_empty_volume();
    test_spare_index_and_abort();
    test_random_volumes();

    in_push <= 1'b0;
    for (n = 0; centroid_q.size() != 0 && n < 20000; n++) @(posedge clk);
    if (centroid_q.size() != 0) begin
      mismatches++;
      $display("%0t missing results: expected %0d more actual none", $time, centroid_q.size());
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bmc_pkg.sv
hdl/bmc_front.sv
hdl/bmc_queue.sv
hdl/bmc_back.sv
hdl/binary_mask_centroid_unit.sv
hdl/bmc_checker.sv
dv/tb_top.sv
